@@ rtl/iqlc_pkg.sv @@
// Shared types and constants of the IQ envelope log compressor.
package iqlc_pkg;

    // Field and register widths
    localparam int PACKED_W   = 32;
    localparam int I_LSB      = PACKED_W / 2;
    localparam int DR_W       = 6;
    localparam int REF_W      = 5;
    localparam int CFG_DATA_W = DR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int LEVEL_W    = 9;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DYN_RANGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_LOG2  = 1'b1;

    // Register reset values
    localparam logic [DR_W-1:0]  DR_RESET  = 6'd30;
    localparam logic [REF_W-1:0] REF_RESET = 5'd26;

    // Parameter defaults
    localparam int HALF_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Magnitude and log2 formats
    localparam int MAG_W     = 32;
    localparam int LEAD_W    = 5;
    localparam int MANT_W    = 31;
    localparam int FRAC_BITS = 12;
    localparam int LOG_W     = LEAD_W + FRAC_BITS;

    // dB arithmetic: 10*log10(2) in Q2.16
    localparam int K_W    = 19;
    localparam int K_FRAC = 16;
    localparam logic signed [K_W-1:0] TEN_LOG10_2_Q16 = 19'sd197283;
    localparam int DIFF_W = LOG_W + 1;
    localparam int PROD_W = DIFF_W + K_W;
    localparam int S_FRAC = FRAC_BITS + K_FRAC;
    localparam int SUM_W  = PROD_W + 1;
    localparam int DB_W   = 20;
    localparam int SCALE_W = DB_W + 8;
    localparam int T_W    = 16;
    localparam int DIV_BITS = LEVEL_W;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // Item handed from the front end to the back end
    typedef struct packed {
        logic              zero;
        logic [LEAD_W-1:0] lead;
        logic [MANT_W-1:0] mant;
    } front_item_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

endpackage

@@ rtl/iqlc_front.sv @@
// Front end: request intake, power computation and normalisation of the magnitude.
module iqlc_front #(
    parameter int HALF_WIDTH = iqlc_pkg::HALF_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [iqlc_pkg::PACKED_W-1:0] s_packed_sample,
    input  iqlc_pkg::queue_flags_t        q_flags,
    output logic                          push,
    output iqlc_pkg::front_item_t         push_item
);

    localparam int PW = 2 * HALF_WIDTH;
    localparam int MW = iqlc_pkg::MAG_W;
    localparam int LW = iqlc_pkg::LEAD_W;

    logic                 en;
    logic signed [HALF_WIDTH-1:0] i_s, q_s;
    logic signed [PW-1:0] i_sq, q_sq;

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [PW-1:0] i_sq_reg, q_sq_reg;
    logic [MW-1:0] mag_reg;
    logic [MW-1:0] na_x, nb_x, na_x_reg, nb_x_reg;
    logic [LW-1:0] na_sh, nb_sh, na_sh_reg, nb_sh_reg;
    logic          s3_zero_reg, s4_zero_reg;

    // advance the whole front end while the queue has room
    assign en      = !q_flags.full;
    assign s_ready = en;
    assign push    = s4_valid_reg && en;

    assign i_s  = s_packed_sample[iqlc_pkg::I_LSB +: HALF_WIDTH];
    assign q_s  = s_packed_sample[0 +: HALF_WIDTH];
    assign i_sq = i_s * i_s;
    assign q_sq = q_s * q_s;

    // leading-one search, upper three steps
    always_comb begin
        na_x  = mag_reg;
        na_sh = '0;
        if (na_x[MW-1 -: MW/2] == '0) begin
            na_x  = na_x << (MW/2);
            na_sh = na_sh + LW'(MW/2);
        end
        if (na_x[MW-1 -: MW/4] == '0) begin
            na_x  = na_x << (MW/4);
            na_sh = na_sh + LW'(MW/4);
        end
        if (na_x[MW-1 -: MW/8] == '0) begin
            na_x  = na_x << (MW/8);
            na_sh = na_sh + LW'(MW/8);
        end
    end

    // leading-one search, last two steps
    always_comb begin
        nb_x  = na_x_reg;
        nb_sh = na_sh_reg;
        if (nb_x[MW-1 -: 2] == '0) begin
            nb_x  = nb_x << 2;
            nb_sh = nb_sh + LW'(2);
        end
        if (!nb_x[MW-1]) begin
            nb_x  = nb_x << 1;
            nb_sh = nb_sh + LW'(1);
        end
    end

    assign push_item.zero = s4_zero_reg;
    assign push_item.lead = LW'(MW-1) - nb_sh_reg;
    assign push_item.mant = nb_x_reg[MW-1:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            i_sq_reg    <= $unsigned(i_sq);
            q_sq_reg    <= $unsigned(q_sq);
            mag_reg     <= MW'(i_sq_reg) + MW'(q_sq_reg);
            na_x_reg    <= na_x;
            na_sh_reg   <= na_sh;
            s3_zero_reg <= (mag_reg == '0);
            nb_x_reg    <= nb_x;
            nb_sh_reg   <= nb_sh;
            s4_zero_reg <= s3_zero_reg;
        end
    end

endmodule

@@ rtl/iqlc_queue.sv @@
// Short queue between the front end and the back end.
module iqlc_queue #(
    parameter int DEPTH = iqlc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  iqlc_pkg::front_item_t  push_item,
    input  logic                   pop,
    output iqlc_pkg::front_item_t  head_item,
    output iqlc_pkg::queue_flags_t flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iqlc_pkg::front_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign flags.full  = (count_reg == CNT_W'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !flags.full)
        else $error("front end pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !flags.empty)
        else $error("back end popped an empty queue");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && !flags.full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone push");

endmodule

@@ rtl/iqlc_back.sv @@
// Back end: log2 by repeated squaring, dB scaling and level division.
module iqlc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  iqlc_pkg::queue_flags_t        q_flags,
    input  iqlc_pkg::front_item_t         head_item,
    output logic                          pop,
    input  logic [iqlc_pkg::DR_W-1:0]     dyn_range,
    input  logic [iqlc_pkg::REF_W-1:0]    ref_log2,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [iqlc_pkg::LEVEL_W-1:0]  m_pixel_level
);

    localparam int NF  = iqlc_pkg::FRAC_BITS;
    localparam int MTW = iqlc_pkg::MANT_W;
    localparam int LW  = iqlc_pkg::LEAD_W;
    localparam int ND  = iqlc_pkg::DIV_BITS;
    localparam int TW  = iqlc_pkg::T_W;
    localparam int QW  = iqlc_pkg::LEVEL_W;

    logic adv;

    // squaring chain, stage 0 holds the popped item
    logic           sq_valid_reg [0:NF];
    logic           sq_zero_reg  [0:NF];
    logic [LW-1:0]  sq_lead_reg  [0:NF];
    logic [MTW-1:0] sq_m_reg     [0:NF];
    logic [NF-1:0]  sq_frac_reg  [0:NF];

    // dB stages
    logic                                  d1_valid_reg, d2_valid_reg;
    logic                                  d1_kill_reg, d2_kill_reg;
    logic signed [iqlc_pkg::PROD_W-1:0]    prod_reg;
    logic [iqlc_pkg::DB_W-1:0]             dbq12_reg;
    logic signed [iqlc_pkg::DIFF_W-1:0]    diff;
    logic signed [iqlc_pkg::SUM_W-1:0]     s_sum;
    logic                                  s_pos;
    logic [iqlc_pkg::SCALE_W-1:0]          scaled;
    logic [TW-1:0]                         t_val;

    // division chain, stage 0 holds the dividend
    logic          dv_valid_reg [0:ND];
    logic          dv_kill_reg  [0:ND];
    logic          dv_sat_reg   [0:ND];
    logic [TW-1:0] dv_rem_reg   [0:ND];
    logic [QW-1:0] dv_q_reg     [0:ND];

    logic          m_valid_reg;
    logic [QW-1:0] m_pixel_level_reg;
    logic [QW-1:0] level;

    // the whole back end moves while the output register is free or drained
    assign adv = !m_valid_reg || m_ready;
    assign pop = adv && !q_flags.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_valid_reg[0] <= !q_flags.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_zero_reg[0] <= head_item.zero;
            sq_lead_reg[0] <= head_item.lead;
            sq_m_reg[0]    <= head_item.mant;
            sq_frac_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < NF; j++) begin : g_sq
        logic [2*MTW-1:0] sq;
        logic [MTW:0]     top;
        logic             bit_out;
        logic [MTW-1:0]   m_next;

        // one fraction bit per stage: square, then renormalise
        assign sq      = sq_m_reg[j] * sq_m_reg[j];
        assign top     = sq[2*MTW-1 -: MTW+1];
        assign bit_out = top[MTW];
        assign m_next  = bit_out ? top[MTW:1] : top[MTW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[j+1] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[j+1] <= sq_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_zero_reg[j+1] <= sq_zero_reg[j];
                sq_lead_reg[j+1] <= sq_lead_reg[j];
                sq_m_reg[j+1]    <= m_next;
                sq_frac_reg[j+1] <= {sq_frac_reg[j][NF-2:0], bit_out};
            end
        end
    end

    assign diff = $signed({1'b0, sq_lead_reg[NF], sq_frac_reg[NF]})
                - $signed({1'b0, ref_log2, {NF{1'b0}}});

    assign s_sum = iqlc_pkg::SUM_W'($signed({1'b0, dyn_range, {iqlc_pkg::S_FRAC{1'b0}}}))
                 + iqlc_pkg::SUM_W'(prod_reg);
    assign s_pos = !s_sum[iqlc_pkg::SUM_W-1] && (s_sum != '0);

    // times 255 as shift and subtract, drop the 12 fraction bits
    assign scaled = {dbq12_reg, 8'b0} - iqlc_pkg::SCALE_W'(dbq12_reg);
    assign t_val  = scaled[NF +: TW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg    <= 1'b0;
            d2_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            d1_valid_reg    <= sq_valid_reg[NF];
            d2_valid_reg    <= d1_valid_reg;
            dv_valid_reg[0] <= d2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_kill_reg    <= sq_zero_reg[NF];
            prod_reg       <= diff * iqlc_pkg::TEN_LOG10_2_Q16;
            d2_kill_reg    <= d1_kill_reg || !s_pos;
            dbq12_reg      <= s_sum[iqlc_pkg::S_FRAC - NF +: iqlc_pkg::DB_W];
            dv_kill_reg[0] <= d2_kill_reg;
            dv_rem_reg[0]  <= t_val;
            dv_sat_reg[0]  <= t_val >= TW'({dyn_range, {ND{1'b0}}});
            dv_q_reg[0]    <= '0;
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_div
        localparam int B = ND - 1 - j;
        logic [TW-1:0] trial;
        logic          take;

        // restoring division, one quotient bit per stage, most significant first
        assign trial = TW'(dyn_range) << B;
        assign take  = dv_rem_reg[j] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_kill_reg[j+1] <= dv_kill_reg[j];
                dv_sat_reg[j+1]  <= dv_sat_reg[j];
                dv_rem_reg[j+1]  <= take ? dv_rem_reg[j] - trial : dv_rem_reg[j];
                dv_q_reg[j+1]    <= dv_q_reg[j] | (QW'(take) << B);
            end
        end
    end

    always_comb begin
        if (dv_kill_reg[ND] || (dyn_range == '0)) begin
            level = '0;
        end else if (dv_sat_reg[ND]) begin
            level = iqlc_pkg::LEVEL_MAX;
        end else begin
            level = dv_q_reg[ND];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid_reg[ND];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pixel_level_reg <= level;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_level = m_pixel_level_reg;

endmodule

@@ rtl/iq_envelope_log_compressor_core.sv @@
// Top level of the IQ envelope log compressor: config registers, front end, queue, back end.
// Throughput: one request per cycle, sustained while m_ready stays high.
// The path from input acceptance to m_valid runs through the twelve squaring stages of
//   the log2 unit and the nine-stage level divider; output stalls lengthen it.
// Reset (aresetn low, synchronous): all stages and the queue empty, dynamic range 30 dB,
//   reference exponent 26; payload registers keep whatever they held.
module iq_envelope_log_compressor_core #(
    parameter int HALF_WIDTH  = iqlc_pkg::HALF_WIDTH_DEF,
    parameter int QUEUE_DEPTH = iqlc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [iqlc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iqlc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // input requests
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [iqlc_pkg::PACKED_W-1:0]   s_packed_sample,
    // result requests
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [iqlc_pkg::LEVEL_W-1:0]    m_pixel_level
);

    logic [iqlc_pkg::DR_W-1:0]  dyn_range_reg;
    logic [iqlc_pkg::REF_W-1:0] ref_log2_reg;

    iqlc_pkg::queue_flags_t q_flags;
    iqlc_pkg::front_item_t  push_item;
    iqlc_pkg::front_item_t  head_item;
    logic                   push;
    logic                   pop;

    // Configuration: write straight into the register the index selects; drop
    // writes to any other index. The user must write only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dyn_range_reg <= iqlc_pkg::DR_RESET;
            ref_log2_reg  <= iqlc_pkg::REF_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                iqlc_pkg::REG_DYN_RANGE: dyn_range_reg <= cfg_wr_data[iqlc_pkg::DR_W-1:0];
                iqlc_pkg::REG_REF_LOG2:  ref_log2_reg  <= cfg_wr_data[iqlc_pkg::REF_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: accept a request, square and sum the I and Q halves, then
    // normalise the power so its leading one sits at the top. Only the queue's
    // full flag stalls it, so s_ready has no combinational path from m_ready.
    iqlc_front #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_packed_sample (s_packed_sample),
        .q_flags         (q_flags),
        .push            (push),
        .push_item       (push_item)
    );

    // Queue: absorb the front end's in-flight requests while the back end
    // is held by a stalled output.
    iqlc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .flags     (q_flags)
    );

    // Back end: log2 fraction by repeated squaring, subtract the reference,
    // scale to dB, clamp at the floor, divide down to the pixel level and saturate at the top.
    // The output register holds a result until taken; the back end advances
    // whenever that register is empty or being drained.
    iqlc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_flags       (q_flags),
        .head_item     (head_item),
        .pop           (pop),
        .dyn_range     (dyn_range_reg),
        .ref_log2      (ref_log2_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_level (m_pixel_level)
    );

endmodule

@@ tb/sv/iq_envelope_log_compressor_core_tb.sv @@
// Self-checking testbench of the IQ envelope log compressor core.
`timescale 1ns / 1ps

module iq_envelope_log_compressor_core_tb;
    import iqlc_pkg::*;

    // 10*log10(2) in Q2.16, and the ceiling of the level field
    localparam longint DB_PER_OCTAVE_Q16 = 197283;
    localparam longint LEVEL_CEILING     = 511;
    localparam int     SAMPLES_PER_PHASE = 125;
    localparam int     PHASE_COUNT       = 14;
    localparam int     DRAIN_CYCLES      = 40;
    localparam int     REPORT_LIMIT      = 10;

    // Predicts the pixel level of every accepted sample and checks the results in order.
    class level_scoreboard;
        logic [LEVEL_W-1:0] pixel_levels[$];
        logic [DR_W-1:0]    dyn_range_db;
        logic [REF_W-1:0]   ref_log2;
        int                 faults;

        function new();
            dyn_range_db = DR_RESET;
            ref_log2     = REF_RESET;
            faults       = 0;
        endfunction

        // Mirror a register write; the reference exponent keeps its low five bits.
        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_DYN_RANGE)
                dyn_range_db = data[DR_W-1:0];
            else if (index == REG_REF_LOG2)
                ref_log2 = data[REF_W-1:0];
        endfunction

        function logic [LEVEL_W-1:0] predict_level(logic [PACKED_W-1:0] word);
            logic signed [15:0] i_half;
            logic signed [15:0] q_half;
            longint i_s, q_s, power, lead, mant, frac, log_q12, diff, sum, db_q12, level;
            i_half = word[31:16];
            q_half = word[15:0];
            i_s    = i_half;
            q_s    = q_half;
            power  = i_s * i_s + q_s * q_s;
            if (power == 0 || dyn_range_db == 0)
                return '0;
            // leading one gives the integer part of log2
            lead = 31;
            while (lead > 0 && ((power >> lead) & 1) == 0)
                lead--;
            // normalise to Q1.30, then square twelve times for the fraction bits
            if (lead == 31)
                mant = power >> 1;
            else
                mant = power << (30 - lead);
            frac = 0;
            for (int step = 0; step < FRAC_BITS; step++) begin
                mant = (mant * mant) >> 30;
                frac = frac << 1;
                if (mant >= (longint'(1) << 31)) begin
                    frac = frac | 1;
                    mant = mant >> 1;
                end
            end
            log_q12 = (lead << FRAC_BITS) | frac;
            diff    = log_q12 - (longint'(ref_log2) << FRAC_BITS);
            sum     = (longint'(dyn_range_db) << 28) + diff * DB_PER_OCTAVE_Q16;
            if (sum <= 0)
                return '0;
            db_q12 = sum >> 16;
            level  = (db_q12 * 255) / (longint'(dyn_range_db) << FRAC_BITS);
            if (level > LEVEL_CEILING)
                level = LEVEL_CEILING;
            return level[LEVEL_W-1:0];
        endfunction

        function void note_request(logic [PACKED_W-1:0] word);
            pixel_levels.push_back(predict_level(word));
        endfunction

        function void check_result(logic [LEVEL_W-1:0] got);
            logic [LEVEL_W-1:0] want;
            if (pixel_levels.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("unexpected result: pixel_level %0d", got);
                return;
            end
            want = pixel_levels.pop_front();
            if (got !== want) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("pixel_level mismatch: expected %0d, actual %0d", want, got);
            end
        endfunction

        function int pending();
            return pixel_levels.size();
        endfunction
    endclass

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = REG_DYN_RANGE;
    logic [CFG_DATA_W-1:0] cfg_wr_data     = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [PACKED_W-1:0]   s_packed_sample = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [LEVEL_W-1:0]    m_pixel_level;

    // idle rates of the two sides, in percent of cycles
    int send_idle_pct = 29;
    int recv_idle_pct = 82;

    level_scoreboard levels = new();

    iq_envelope_log_compressor_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_packed_sample(s_packed_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_level  (m_pixel_level)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result side at random; one draw per cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watch both handshakes. Every value read here is the one held before the edge,
    // since all drivers update through nonblocking assignments.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                levels.note_request(s_packed_sample);
            if (m_valid && m_ready)
                levels.check_result(m_pixel_level);
        end
    end

    // Offer one request; idle first at the current rate, then hold valid and payload
    // until the block takes it. Returns at the accepting edge.
    task automatic send_sample(input logic [PACKED_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_packed_sample <= word;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Drop valid and wait until every predicted level has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (levels.pending() != 0);
    endtask

    // Write both registers on consecutive edges; the enable stays high across the pair.
    task automatic write_registers(input logic [CFG_DATA_W-1:0] dr_data,
                                   input logic [CFG_DATA_W-1:0] ref_data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_DYN_RANGE;
        cfg_wr_data <= dr_data;
        @(posedge aclk);
        levels.set_register(REG_DYN_RANGE, dr_data);
        cfg_index   <= REG_REF_LOG2;
        cfg_wr_data <= ref_data;
        @(posedge aclk);
        levels.set_register(REG_REF_LOG2, ref_data);
        cfg_wr_en   <= 1'b0;
    endtask

    // One signed half: full-scale extremes, zero, unit values, or a log-spread magnitude
    // of either sign, so that every leading-one position turns up.
    function automatic logic [15:0] random_half();
        logic [15:0] half;
        case ($urandom_range(0, 9))
            0: half = 16'h8000;
            1: half = 16'h7FFF;
            2: half = 16'h0000;
            3: half = $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            4, 5, 6: begin
                half = 16'($urandom) >> $urandom_range(0, 15);
                if ($urandom_range(0, 1))
                    half = -half;
            end
            default: half = 16'($urandom);
        endcase
        return half;
    endfunction

    function automatic logic [PACKED_W-1:0] random_sample();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return {random_half(), random_half()};
    endfunction

    // Directed samples: zero power, full-scale corners, unit magnitudes, single-axis
    // extremes and mixed signs.
    localparam logic [PACKED_W-1:0] DIRECTED_SAMPLES[20] = '{
        32'h0000_0000, 32'h8000_8000, 32'h7FFF_7FFF, 32'h8000_0000,
        32'h0000_8000, 32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF,
        32'h7FFF_0000, 32'h0000_7FFF, 32'h8001_0001, 32'h1234_5678,
        32'hA5A5_5A5A, 32'h0001_FFFF, 32'h4000_4000, 32'h0000_FFFF,
        32'hFFFF_0000, 32'h0010_0010, 32'h0100_0100, 32'h8000_7FFF
    };

    // Register settings per phase; phase 0 runs at the reset values. Covered: the
    // narrowest range with the lowest reference (saturates), the widest legal range,
    // zero range, all data bits set (reference keeps its low five bits), and a mix.
    localparam logic [CFG_DATA_W-1:0] PHASE_DR[7]  = '{6'd30, 6'd1, 6'd60, 6'd0,
                                                       6'd63, 6'd2, 6'd45};
    localparam logic [CFG_DATA_W-1:0] PHASE_REF[7] = '{6'd26, 6'd0, 6'd31, 6'd26,
                                                       6'h3F, 6'd31, 6'd10};

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_SAMPLES[n])
            send_sample(DIRECTED_SAMPLES[n]);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // swap the idle rates after five phases, then run flat out
            if (phase == 5) begin
                send_idle_pct = 82;
                recv_idle_pct = 29;
            end else if (phase == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase > 0) begin
                wait_idle();
                if (phase < 7)
                    write_registers(PHASE_DR[phase], PHASE_REF[phase]);
                else
                    write_registers(6'($urandom_range(1, 60)), 6'($urandom_range(0, 63)));
            end
            for (int n = 0; n < SAMPLES_PER_PHASE; n++)
                send_sample(random_sample());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (levels.pending() != 0) begin
            levels.faults++;
            $display("%0d predicted levels never arrived", levels.pending());
        end
        if (levels.faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
